>>> hw/rtl/wgm_pkg.sv
// ============================================================================
// wgm_pkg
// Shared types, constants and helpers of the wildcard glob matcher.
// ============================================================================
package wgm_pkg;

    localparam int MAX_PATTERN_DEF = 32;

    localparam logic [7:0] SYM_STAR = 8'h2A;
    localparam logic [7:0] SYM_ANY  = 8'h3F;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_TEXT   = 2'd2,
        ACT_END    = 2'd3
    } action_t;

    typedef struct packed {
        logic append;
        logic clear;
        logic text;
        logic done;
    } item_ctrl_t;

    function automatic logic [7:0] fold_sym(input logic [7:0] c, input logic en);
        logic is_upper;
        is_upper = (c >= 8'h41) && (c <= 8'h5A);
        return (en && is_upper) ? (c | 8'h20) : c;
    endfunction

endpackage

>>> hw/rtl/wildcard_glob_matcher_unit.sv
// ============================================================================
// wildcard_glob_matcher_unit
// Streaming glob matcher ('*' any run, '?' any one symbol), optional case fold.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_stall, action, symbol) carries one request per
//   cycle unless stalled: append pattern symbol, clear pattern, text symbol,
//   end of text. Only end of text produces a result on the output channel
//   (out_valid/out_stall, matched, pattern_overflow).
//   Config channel (cfg_valid/cfg_ready, cfg_data) writes fold_case; it is
//   always ready. The user must write it only while the matcher is idle;
//   the block does not enforce this. A request is held in the input register
//   and evaluated from it; its result is registered to the outputs. The unit
//   takes one request per cycle while not stalled; the active position
//   vector is updated by prefix star closure plus per-position compare.
//   Reset: empty pattern, overflow cleared, position zero active, fold_case 1.
//   A stalled result holds; the input register keeps filling and only an
//   end-of-text request waits, which then raises in_stall.
//   Patterns longer than MAX_PATTERN set overflow until the next clear.
// ============================================================================
module wildcard_glob_matcher_unit #(
    parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] action,
    input  logic [7:0] symbol,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       matched,
    output logic       pattern_overflow,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);
    import wgm_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic                 in_vld_reg;
    logic                 in_vld_next;
    action_t              action_reg;
    logic [7:0]           symbol_reg;
    logic                 fold_reg;
    logic                 fold_next;
    logic                 out_vld_reg;
    logic                 out_vld_next;
    logic                 matched_reg;
    logic                 ovf_out_reg;

    item_ctrl_t           ctrl;
    logic                 advance;
    logic [MAX_PATTERN-1:0] star_vec;
    logic [MAX_PATTERN-1:0] hit_vec;
    logic [LEN_W-1:0]     pat_len;
    logic                 overflow;
    logic                 verdict;
    logic [MAX_PATTERN:0] active;

    always_comb
    begin
        ctrl = '0;
        unique case (action_reg)
            ACT_APPEND: ctrl.append = 1'b1;
            ACT_CLEAR:  ctrl.clear  = 1'b1;
            ACT_TEXT:   ctrl.text   = 1'b1;
            ACT_END:    ctrl.done   = 1'b1;
            default:    ctrl = '0;
        endcase
    end

    assign advance  = in_vld_reg && (!ctrl.done || !out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;

    assign in_vld_next  = in_stall ? in_vld_reg : in_valid;
    assign out_vld_next = (advance && ctrl.done) ? 1'b1 :
                          (out_stall ? out_vld_reg : 1'b0);
    assign fold_next    = (cfg_valid && cfg_ready) ? cfg_data : fold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            fold_reg    <= 1'b1;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            fold_reg    <= fold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            action_reg <= action_t'(action);
            symbol_reg <= symbol;
        end
        if (advance && ctrl.done)
        begin
            matched_reg <= verdict;
            ovf_out_reg <= overflow;
        end
    end

    wgm_pattern_store #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .ctrl      (ctrl),
        .symbol    (symbol_reg),
        .fold_case (fold_reg),
        .star_vec  (star_vec),
        .hit_vec   (hit_vec),
        .pat_len   (pat_len),
        .overflow  (overflow)
    );

    wgm_nfa #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_nfa (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance),
        .ctrl     (ctrl),
        .star_vec (star_vec),
        .hit_vec  (hit_vec),
        .pat_len  (pat_len),
        .overflow (overflow),
        .verdict  (verdict),
        .active   (active)
    );

    assign cfg_ready        = 1'b1;
    assign out_valid        = out_vld_reg;
    assign matched          = matched_reg;
    assign pattern_overflow = ovf_out_reg;

    a_ovf_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(matched && pattern_overflow))
        else $error("match reported with pattern overflow");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && ctrl.clear) |=> (pat_len == '0 && !overflow))
        else $error("clear did not empty pattern");

    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (ctrl.done || ctrl.clear)) |=> (active == (MAX_PATTERN + 1)'(1)))
        else $error("active set not rearmed");

    a_stall_only_end: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (ctrl.done && out_vld_reg && out_stall))
        else $error("input stalled without a blocked result");

endmodule

>>> hw/rtl/wgm_pattern_store.sv
// ============================================================================
// wgm_pattern_store
// Pattern symbol cells with length and overflow tracking; per-position
// star and hit flags ('?' or equal symbol) for the current text symbol.
// ============================================================================
module wgm_pattern_store #(
    parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               fire,
    input  wgm_pkg::item_ctrl_t                ctrl,
    input  logic [7:0]                         symbol,
    input  logic                               fold_case,
    output logic [MAX_PATTERN-1:0]             star_vec,
    output logic [MAX_PATTERN-1:0]             hit_vec,
    output logic [$clog2(MAX_PATTERN+1)-1:0]   pat_len,
    output logic                               overflow
);
    import wgm_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [7:0]       store_reg [MAX_PATTERN];
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             room;
    logic [7:0]       fsym;

    assign room = len_reg < LEN_W'(MAX_PATTERN);
    assign fsym = fold_sym(symbol, fold_case);

    always_comb
    begin
        len_next = len_reg;
        ovf_next = ovf_reg;
        if (fire && ctrl.clear)
        begin
            len_next = '0;
            ovf_next = 1'b0;
        end
        else if (fire && ctrl.append)
        begin
            if (room)
                len_next = len_reg + LEN_W'(1);
            else
                ovf_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            len_reg <= len_next;
            ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && ctrl.append && room)
            store_reg[len_reg[IDX_W-1:0]] <= symbol;
    end

    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            star_vec[i] = (LEN_W'(i) < len_reg) && (store_reg[i] == SYM_STAR);
            hit_vec[i]  = (LEN_W'(i) < len_reg) && (store_reg[i] != SYM_STAR) &&
                          ((store_reg[i] == SYM_ANY) ||
                           (fold_sym(store_reg[i], fold_case) == fsym));
        end
    end

    assign pat_len  = len_reg;
    assign overflow = ovf_reg;

endmodule

>>> hw/rtl/wgm_nfa.sv
// ============================================================================
// wgm_nfa
// Active pattern position set with parallel-prefix star closure and
// end-of-text verdict.
// ============================================================================
module wgm_nfa #(
    parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               fire,
    input  wgm_pkg::item_ctrl_t                ctrl,
    input  logic [MAX_PATTERN-1:0]             star_vec,
    input  logic [MAX_PATTERN-1:0]             hit_vec,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]   pat_len,
    input  logic                               overflow,
    output logic                               verdict,
    output logic [MAX_PATTERN:0]               active
);
    import wgm_pkg::*;

    localparam int LEVELS = $clog2(MAX_PATTERN + 1);

    logic [MAX_PATTERN:0] active_reg;
    logic [MAX_PATTERN:0] active_next;
    logic [MAX_PATTERN:0] closed;
    logic [MAX_PATTERN:0] stepped;

    // closure: position j+1 inherits activity from j across a star
    always_comb
    begin
        logic [MAX_PATTERN:0] g;
        logic [MAX_PATTERN:0] p;
        g = active_reg;
        p = {star_vec, 1'b0};
        for (int k = 0; k < LEVELS; k++)
        begin
            g = g | (p & (g << (1 << k)));
            p = p & (p << (1 << k));
        end
        closed = g;
    end

    assign stepped = {1'b0, closed[MAX_PATTERN-1:0] & star_vec} |
                     {closed[MAX_PATTERN-1:0] & hit_vec, 1'b0};

    assign verdict = !overflow && closed[pat_len];

    always_comb
    begin
        active_next = active_reg;
        priority if (fire && (ctrl.clear || ctrl.done))
            active_next = (MAX_PATTERN + 1)'(1);
        else if (fire && ctrl.text)
            active_next = stepped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= (MAX_PATTERN + 1)'(1);
        else
            active_reg <= active_next;
    end

    assign active = active_reg;

endmodule
